@@ rtl/idd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package idd_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_PREPEND = 2'd1,
    FUNC_DEQUEUE = 2'd2,
    FUNC_DELETE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] item_id;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] removed_id;
    logic [15:0] head_id;
    logic [4:0]  length;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/idd_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module idd_store #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic      [ID_WIDTH-1:0]        rd_data_o,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  wire logic [ID_WIDTH-1:0]        wr_data_i
);

  logic [ID_WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/id_deque_with_delete.sv @@
// From accept to result: the operation executes (a dequeue then takes in the removed word, a
// delete scans the held entries), the head entry is read and the result is registered for output.
// Only one word is in flight at a time, so the next accept waits until that result has been
// registered; the delete scan reads one store entry per cycle.
// A result waiting in the output register does not block the next accept.
// Reset clears head, count and control; the entry store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module id_deque_with_delete #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire idd_pkg::in_word_t    in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output idd_pkg::out_word_t        out_word_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DEQ   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_HREAD = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(o);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]          state_q, state_d;
  idd_pkg::func_e      func_q, func_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  idd_pkg::status_e    status_q, status_d;
  logic [ID_WIDTH-1:0] removed_q, removed_d;
  logic [CW-1:0]       iss_q, iss_d;
  logic                pv_q, pv_d;
  logic [CW-1:0]       poff_q, poff_d;
  logic                found_q, found_d;
  logic                out_valid_q, out_valid_d;
  idd_pkg::out_word_t  out_q, out_d;

  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr, head_m1;
  logic [ID_WIDTH-1:0] wr_data, rdata;
  logic                match;
  logic [63:0]         in_id_w, rd_w, removed_w, cnt_w;

  idd_store #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rdata),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign in_id_w   = 64'(in_word_i.item_id);
  assign rd_w      = 64'(rdata);
  assign removed_w = 64'(removed_q);
  assign cnt_w     = 64'(count_q);
  assign head_m1   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign match     = (rdata == id_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    id_d        = id_q;
    head_d      = head_q;
    count_d     = count_q;
    status_d    = status_q;
    removed_d   = removed_q;
    iss_d       = iss_q;
    pv_d        = 1'b0;
    poff_d      = poff_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    wr_en       = 1'b0;
    wr_addr     = head_q;
    wr_data     = id_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = in_word_i.func;
          id_d      = in_id_w[ID_WIDTH-1:0];
          status_d  = idd_pkg::ST_OK;
          removed_d = '0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_HREAD;
        case (func_q)
          idd_pkg::FUNC_APPEND: begin
            if (count_q == CW'(DEPTH)) begin
              status_d = idd_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = slot_of(head_q, count_q);
              count_d = count_q + CW'(1);
            end
          end
          idd_pkg::FUNC_PREPEND: begin
            if (count_q == CW'(DEPTH)) begin
              status_d = idd_pkg::ST_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = head_m1;
              head_d  = head_m1;
              count_d = count_q + CW'(1);
            end
          end
          idd_pkg::FUNC_DEQUEUE: begin
            if (count_q == '0) begin
              status_d = idd_pkg::ST_EMPTY;
            end else begin
              rd_en   = 1'b1;
              head_d  = slot_of(head_q, CW'(1));
              count_d = count_q - CW'(1);
              state_d = S_DEQ;
            end
          end
          idd_pkg::FUNC_DELETE: begin
            if (count_q == '0) begin
              status_d = idd_pkg::ST_EMPTY;
            end else begin
              iss_d   = '0;
              found_d = 1'b0;
              state_d = S_SCAN;
            end
          end
          default: begin
            state_d = S_HREAD;
          end
        endcase
      end
      S_DEQ: begin
        removed_d = rdata;
        state_d   = S_HREAD;
      end
      S_SCAN: begin
        // issue one read per entry; the word read last cycle is checked now
        if (iss_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = slot_of(head_q, iss_q);
          iss_d   = iss_q + CW'(1);
          pv_d    = 1'b1;
          poff_d  = iss_q;
        end
        if (pv_q) begin
          if (found_q) begin
            // shift each later entry one slot toward the head
            wr_en   = 1'b1;
            wr_addr = slot_of(head_q, poff_q - CW'(1));
            wr_data = rdata;
          end else if (match) begin
            found_d = 1'b1;
          end
          if (poff_q + CW'(1) == count_q) begin
            if (found_q || match) begin
              count_d = count_q - CW'(1);
            end else begin
              status_d = idd_pkg::ST_NOTFOUND;
            end
            state_d = S_HREAD;
          end
        end
      end
      S_HREAD: begin
        rd_en   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.status     = status_q;
          out_d.removed_id = removed_w[15:0];
          out_d.head_id    = (count_q != '0) ? rd_w[15:0] : 16'd0;
          out_d.length     = cnt_w[4:0];
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    id_q      <= id_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    poff_q    <= poff_d;
    out_q     <= out_d;
  end

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(DEPTH)) && (head_q <= AW'(DEPTH - 1)))
    else $error("head or count out of range");

  a_count_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_SCAN))
    else $error("count changed outside an operation");

  a_scan_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && wr_en) |-> (found_q && pv_q))
    else $error("compaction write before a match");

endmodule

`default_nettype wire
